// ===== hdl/tfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_pkg: shared types and constants for the triangle formation block
// Payload structs, configuration set, rotation matrix and pipeline stage map.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam int ADDR_W     = 6;
  localparam int NUM_STAGES = 7;

  // pipeline stage positions in the load vector
  localparam int STG_LEN  = 0;
  localparam int STG_MUL  = 1;
  localparam int STG_ABC  = 2;
  localparam int STG_PROD = 3;
  localparam int STG_FULL = 4;
  localparam int STG_ROW  = 5;
  localparam int STG_OUT  = 6;

  // 1/sqrt3 in Q0.30, split into two 15-bit halves
  localparam logic [29:0] INV_SQRT3_Q30 = 30'd619925131;
  localparam logic [14:0] K_HI          = INV_SQRT3_Q30[29:15];
  localparam logic [14:0] K_LO          = INV_SQRT3_Q30[14:0];

  localparam logic [15:0] SPACING_RST   = 16'd256;
  localparam logic [15:0] BASE_SIZE_RST = 16'd256;
  localparam logic [63:0] QUAT_RST      = 64'h4000_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_SPACING   = 3'd3,
    REG_BASE_SIZE = 3'd4,
    REG_QUAT      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic signed [15:0] size_delta;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [15:0]        spacing;
    logic signed [15:0] base_size;
    logic [63:0]        quat;
  } cfg_t;

  // first two columns of the rotation matrix, Q6.28, one entry per row
  typedef struct packed {
    logic [2:0][33:0] c0;
    logic [2:0][33:0] c1;
  } rot_mat_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } base_t;

  typedef struct packed {
    base_t              base;
    logic signed [33:0] a;
    logic signed [33:0] b;
    logic signed [33:0] c;
  } arm_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/triangle_formation_positions_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_formation_positions_top: three-agent triangle formation placer
// Each input beat carries a centre offset and a size change; each output
// beat carries the nine Q16.16 coordinates of the three agents, rotated by
// the configured quaternion and placed at centre plus offset, saturated.
// Channels: in_valid/in_ready/in_data and out_valid/out_ready/out_data,
// a beat moves when valid and ready are both high. Configuration goes
// through the APB-style port, 64-bit registers at byte address 8*index;
// write it only while no beat is in flight.
// The arm and rotation datapath has seven register stages between input
// beat and output beat; one beat per cycle is taken in steady state while
// the receiver keeps out_ready high.
// Reset (synchronous, rst_n low) empties the pipeline and loads the default
// registers (identity rotation, spacing and size 1.0, centre 0); in_ready
// stays low until a run flag register is set after reset is released.
// When the receiver stalls, each stage holds its beat and empty stages
// still fill, so input is taken until the pipeline is full.
// ----------------------------------------------------------------------------
module triangle_formation_positions_top import tfp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic      [63:0]       prdata,
  output logic                   pready
);

  cfg_t      cfg;
  rot_mat_t  mat;
  pipe_ctl_t ctl;
  arm_t      arm;

  tfp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfp_matrix u_matrix (
    .clk  (clk),
    .quat (cfg.quat),
    .mat  (mat)
  );

  tfp_pipe_ctrl u_pipe_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  tfp_arm u_arm (
    .clk     (clk),
    .ctl     (ctl),
    .cfg     (cfg),
    .in_data (in_data),
    .arm     (arm)
  );

  tfp_rotate u_rotate (
    .clk      (clk),
    .ctl      (ctl),
    .arm      (arm),
    .mat      (mat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/tfp_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_cfg_regs: configuration register file
// APB-style write and read of centre, spacing, base size and quaternion.
// ----------------------------------------------------------------------------
module tfp_cfg_regs import tfp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic      [63:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_CENTER_X:  cfg_nxt.center_x  = pwdata[31:0];
        REG_CENTER_Y:  cfg_nxt.center_y  = pwdata[31:0];
        REG_CENTER_Z:  cfg_nxt.center_z  = pwdata[31:0];
        REG_SPACING:   cfg_nxt.spacing   = pwdata[15:0];
        REG_BASE_SIZE: cfg_nxt.base_size = pwdata[15:0];
        REG_QUAT:      cfg_nxt.quat      = pwdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X:  prdata = {32'd0, cfg_r.center_x};
      REG_CENTER_Y:  prdata = {32'd0, cfg_r.center_y};
      REG_CENTER_Z:  prdata = {32'd0, cfg_r.center_z};
      REG_SPACING:   prdata = {48'd0, cfg_r.spacing};
      REG_BASE_SIZE: prdata = {48'd0, cfg_r.base_size};
      REG_QUAT:      prdata = cfg_r.quat;
      default:       prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x  <= '0;
      cfg_r.center_y  <= '0;
      cfg_r.center_z  <= '0;
      cfg_r.spacing   <= SPACING_RST;
      cfg_r.base_size <= BASE_SIZE_RST;
      cfg_r.quat      <= QUAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tfp_matrix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_matrix: rotation matrix from the configured quaternion
// Two register stages: quaternion products, then the six matrix entries.
// ----------------------------------------------------------------------------
module tfp_matrix import tfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic [63:0] quat,
  output rot_mat_t         mat
);

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  rot_mat_t           mat_r;
  rot_mat_t           mat_nxt;

  assign qw  = $signed(quat[63:48]);
  assign qx  = $signed(quat[47:32]);
  assign qy  = $signed(quat[31:16]);
  assign qz  = $signed(quat[15:0]);
  assign mat = mat_r;

  always_ff @(posedge clk) begin
    ww_r <= qw * qw;
    xx_r <= qx * qx;
    yy_r <= qy * qy;
    zz_r <= qz * qz;
    xy_r <= qx * qy;
    wz_r <= qw * qz;
    xz_r <= qx * qz;
    wy_r <= qw * qy;
    yz_r <= qy * qz;
    wx_r <= qw * qx;
  end

  always_comb begin
    mat_nxt.c0[0] = 34'(ww_r) + 34'(xx_r) - 34'(yy_r) - 34'(zz_r);
    mat_nxt.c1[0] = (34'(xy_r) - 34'(wz_r)) <<< 1;
    mat_nxt.c0[1] = (34'(xy_r) + 34'(wz_r)) <<< 1;
    mat_nxt.c1[1] = 34'(ww_r) - 34'(xx_r) + 34'(yy_r) - 34'(zz_r);
    mat_nxt.c0[2] = (34'(xz_r) - 34'(wy_r)) <<< 1;
    mat_nxt.c1[2] = (34'(yz_r) + 34'(wx_r)) <<< 1;
  end

  always_ff @(posedge clk) begin
    mat_r <= mat_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/tfp_pipe_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_pipe_ctrl: valid tracking and per-stage load enables
// A stage loads when it is empty or the stage after it moves on.
// ----------------------------------------------------------------------------
module tfp_pipe_ctrl import tfp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output pipe_ctl_t ctl
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES:0]   ld;
  logic                  run_r;

  always_comb begin
    ld[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      ld[i] = !valid_r[i] || ld[i+1];
    end
  end

  assign in_ready  = ld[0] & run_r;
  assign out_valid = valid_r[NUM_STAGES-1];
  assign ctl.ld    = ld[NUM_STAGES-1:0];

  always_comb begin
    valid_nxt = valid_r;
    if (ld[0]) begin
      valid_nxt[0] = in_valid & run_r;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (ld[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      run_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      run_r   <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tfp_arm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_arm: arm length and triangle corner coordinates
// Three stages: arm length and base point, split 1/sqrt3 products, a/b/c.
// ----------------------------------------------------------------------------
module tfp_arm import tfp_pkg::*; (
  input  wire logic      clk,
  input  wire pipe_ctl_t ctl,
  input  wire cfg_t      cfg,
  input  wire in_item_t  in_data,
  output arm_t           arm
);

  localparam logic signed [64:0] A_RND = 65'sd536870912;
  localparam logic signed [64:0] C_RND = 65'sd1073741824;

  logic signed [16:0] size;
  logic signed [33:0] l_nxt, l_s1_r, l_s2_r;
  base_t              base_nxt, base_s1_r, base_s2_r;
  logic signed [49:0] lkh_nxt, lkl_nxt, lkh_r, lkl_r;
  logic signed [64:0] lk, a_w, c_w;
  logic signed [34:0] b_w;
  arm_t               arm_nxt, arm_r;

  // stage 1: arm length in Q16.16, centre plus offset
  always_comb begin
    size       = {cfg.base_size[15], cfg.base_size}
               + {in_data.size_delta[15], in_data.size_delta};
    l_nxt      = $signed({1'b0, cfg.spacing}) * size;
    base_nxt.x = {cfg.center_x[31], cfg.center_x} + {in_data.offset_x[31], in_data.offset_x};
    base_nxt.y = {cfg.center_y[31], cfg.center_y} + {in_data.offset_y[31], in_data.offset_y};
    base_nxt.z = {cfg.center_z[31], cfg.center_z} + {in_data.offset_z[31], in_data.offset_z};
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_LEN]) begin
      l_s1_r    <= l_nxt;
      base_s1_r <= base_nxt;
    end
  end

  // stage 2: l times the high and low halves of 1/sqrt3
  always_comb begin
    lkh_nxt = l_s1_r * $signed({1'b0, K_HI});
    lkl_nxt = l_s1_r * $signed({1'b0, K_LO});
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_MUL]) begin
      lkh_r     <= lkh_nxt;
      lkl_r     <= lkl_nxt;
      l_s2_r    <= l_s1_r;
      base_s2_r <= base_s1_r;
    end
  end

  // stage 3: round to nearest, ties up
  always_comb begin
    lk           = (65'(lkh_r) <<< 15) + 65'(lkl_r);
    a_w          = (lk + A_RND) >>> 30;
    c_w          = (lk + C_RND) >>> 31;
    b_w          = (35'(l_s2_r) + 35'sd1) >>> 1;
    arm_nxt.base = base_s2_r;
    arm_nxt.a    = a_w[33:0];
    arm_nxt.c    = c_w[33:0];
    arm_nxt.b    = b_w[33:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_ABC]) begin
      arm_r <= arm_nxt;
    end
  end

  assign arm = arm_r;

endmodule
`default_nettype wire

// ===== hdl/tfp_rotate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfp_rotate: rotation of the three corners and final placement
// Four stages: split products, full products, rounded rows, add and saturate.
// ----------------------------------------------------------------------------
module tfp_rotate import tfp_pkg::*; (
  input  wire logic      clk,
  input  wire pipe_ctl_t ctl,
  input  wire arm_t      arm,
  input  wire rot_mat_t  mat,
  output out_item_t      out_data
);

  localparam logic signed [70:0] ROW_RND = 71'sd134217728;

  function automatic logic [31:0] sat32(input logic signed [43:0] v);
    logic [31:0] r;
    if (v > 44'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -44'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [17:0] ah, bh, ch;
  logic signed [16:0] al, bl, cl;

  logic signed [51:0] pah_nxt[3], pbh_nxt[3], pch_nxt[3];
  logic signed [50:0] pal_nxt[3], pbl_nxt[3], pcl_nxt[3];
  logic signed [51:0] pah_r[3], pbh_r[3], pch_r[3];
  logic signed [50:0] pal_r[3], pbl_r[3], pcl_r[3];
  base_t              base_s4_r, base_s5_r, base_s6_r;

  logic signed [68:0] pa_nxt[3], pb_nxt[3], pc_nxt[3];
  logic signed [68:0] pa_r[3], pb_r[3], pc_r[3];

  logic signed [70:0] t0, t1, t2;
  logic signed [42:0] rv_nxt[3][3];
  logic signed [42:0] rv_r[3][3];

  logic signed [32:0] bsel[3];
  logic [31:0]        pos[3][3];
  out_item_t          out_nxt, out_r;

  // stage 4: matrix column times corner coordinate, 16-bit split
  always_comb begin
    ah = $signed(arm.a[33:16]);
    bh = $signed(arm.b[33:16]);
    ch = $signed(arm.c[33:16]);
    al = $signed({1'b0, arm.a[15:0]});
    bl = $signed({1'b0, arm.b[15:0]});
    cl = $signed({1'b0, arm.c[15:0]});
    for (int i = 0; i < 3; i++) begin
      pah_nxt[i] = $signed(mat.c0[i]) * ah;
      pal_nxt[i] = $signed(mat.c0[i]) * al;
      pch_nxt[i] = $signed(mat.c0[i]) * ch;
      pcl_nxt[i] = $signed(mat.c0[i]) * cl;
      pbh_nxt[i] = $signed(mat.c1[i]) * bh;
      pbl_nxt[i] = $signed(mat.c1[i]) * bl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_PROD]) begin
      for (int i = 0; i < 3; i++) begin
        pah_r[i] <= pah_nxt[i];
        pal_r[i] <= pal_nxt[i];
        pbh_r[i] <= pbh_nxt[i];
        pbl_r[i] <= pbl_nxt[i];
        pch_r[i] <= pch_nxt[i];
        pcl_r[i] <= pcl_nxt[i];
      end
      base_s4_r <= arm.base;
    end
  end

  // stage 5: merge the halves into exact products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_nxt[i] = (69'(pah_r[i]) <<< 16) + 69'(pal_r[i]);
      pb_nxt[i] = (69'(pbh_r[i]) <<< 16) + 69'(pbl_r[i]);
      pc_nxt[i] = (69'(pch_r[i]) <<< 16) + 69'(pcl_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_FULL]) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= pa_nxt[i];
        pb_r[i] <= pb_nxt[i];
        pc_r[i] <= pc_nxt[i];
      end
      base_s5_r <= base_s4_r;
    end
  end

  // stage 6: row sums per corner, rounded Q6.28 x Q16.16 down to Q16.16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t0 = 71'(pa_r[i]) + ROW_RND;
      t1 = 71'(pb_r[i]) - 71'(pc_r[i]) + ROW_RND;
      t2 = ROW_RND - 71'(pb_r[i]) - 71'(pc_r[i]);
      rv_nxt[0][i] = t0[70:28];
      rv_nxt[1][i] = t1[70:28];
      rv_nxt[2][i] = t2[70:28];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_ROW]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          rv_r[k][i] <= rv_nxt[k][i];
        end
      end
      base_s6_r <= base_s5_r;
    end
  end

  // stage 7: add centre plus offset, clamp to 32 bits
  always_comb begin
    bsel[0] = base_s6_r.x;
    bsel[1] = base_s6_r.y;
    bsel[2] = base_s6_r.z;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        pos[k][i] = sat32(44'(bsel[i]) + 44'(rv_r[k][i]));
      end
    end
    out_nxt.first_x  = pos[0][0];
    out_nxt.first_y  = pos[0][1];
    out_nxt.first_z  = pos[0][2];
    out_nxt.second_x = pos[1][0];
    out_nxt.second_y = pos[1][1];
    out_nxt.second_z = pos[1][2];
    out_nxt.third_x  = pos[2][0];
    out_nxt.third_y  = pos[2][1];
    out_nxt.third_z  = pos[2][2];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== bench/formation_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// formation_check: position predictor and comparator for the triangle placer
// Snoops the register port to keep its own copy of the settings, computes
// the nine agent coordinates for every accepted input beat and compares
// each output beat, field by field, with the oldest pending prediction.
// ----------------------------------------------------------------------------
module formation_check import tfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output int                mismatches,
  output int                positions_owed,
  output int                positions_checked
);

  localparam int TOP_BIT = $bits(out_item_t) - 1;

  cfg_t      settings;
  out_item_t expected_positions[$];
  int        bad_count = 0;
  int        owed = 0;
  int        checked = 0;
  string     agent_tag[3] = '{"first", "second", "third"};
  string     axis_tag[3] = '{"x", "y", "z"};

  assign mismatches        = bad_count;
  assign positions_owed    = owed;
  assign positions_checked = checked;

  task automatic flag_mismatch(input string what);
    bad_count++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // round((r0*vx + r1*vy) / 2^28) with the products split into high and low halves
  function automatic longint rotate_row(longint r0, longint r1, longint vx, longint vy);
    longint xh, yh, xl, yl, hi, lo, t;
    xh = vx >>> 16;
    yh = vy >>> 16;
    xl = vx - xh * 65536;
    yl = vy - yh * 65536;
    hi = r0 * xh + r1 * yh;
    lo = r0 * xl + r1 * yl;
    t  = hi + (lo >>> 16);
    return (t + 2048) >>> 12;
  endfunction

  function automatic logic [31:0] clamp_q16(longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t place_agents(in_item_t beat, cfg_t c);
    longint    arm, arm_k, ax, bx, cx, w, x, y, z;
    longint    col0[3], col1[3], px[3], py[3], origin[3];
    out_item_t spot;
    arm   = longint'({48'd0, c.spacing}) *
            (longint'($signed(c.base_size)) + longint'($signed(beat.size_delta)));
    arm_k = arm * longint'(INV_SQRT3_Q30);
    ax    = (arm_k + 64'sd536870912) >>> 30;
    cx    = (arm_k + 64'sd1073741824) >>> 31;
    bx    = (arm + 1) >>> 1;
    w = longint'($signed(c.quat[63:48]));
    x = longint'($signed(c.quat[47:32]));
    y = longint'($signed(c.quat[31:16]));
    z = longint'($signed(c.quat[15:0]));
    // only the first two matrix columns matter, the points lie in z = 0
    col0[0] = w * w + x * x - y * y - z * z;
    col1[0] = 2 * (x * y - w * z);
    col0[1] = 2 * (x * y + w * z);
    col1[1] = w * w - x * x + y * y - z * z;
    col0[2] = 2 * (x * z - w * y);
    col1[2] = 2 * (y * z + w * x);
    px[0] = ax;  py[0] = 0;
    px[1] = -cx; py[1] = bx;
    px[2] = -cx; py[2] = -bx;
    origin[0] = longint'($signed(c.center_x)) + longint'($signed(beat.offset_x));
    origin[1] = longint'($signed(c.center_y)) + longint'($signed(beat.offset_y));
    origin[2] = longint'($signed(c.center_z)) + longint'($signed(beat.offset_z));
    spot = '0;
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        spot[TOP_BIT - 32 * (k * 3 + r) -: 32] =
          clamp_q16(origin[r] + rotate_row(col0[r], col1[r], px[k], py[k]));
      end
    end
    return spot;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      settings.center_x  = '0;
      settings.center_y  = '0;
      settings.center_z  = '0;
      settings.spacing   = SPACING_RST;
      settings.base_size = BASE_SIZE_RST;
      settings.quat      = QUAT_RST;
      expected_positions.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          flag_mismatch($sformatf("output beat %h with nothing pending", out_data));
        end else begin
          want = expected_positions.pop_front();
          checked++;
          for (int f = 0; f < 9; f++) begin
            if (out_data[TOP_BIT - 32 * f -: 32] !== want[TOP_BIT - 32 * f -: 32]) begin
              flag_mismatch($sformatf("%s_%s got %08h want %08h", agent_tag[f / 3],
                axis_tag[f % 3], out_data[TOP_BIT - 32 * f -: 32],
                want[TOP_BIT - 32 * f -: 32]));
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_positions.push_back(place_agents(in_data, settings));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:3])
          REG_CENTER_X:  settings.center_x  = pwdata[31:0];
          REG_CENTER_Y:  settings.center_y  = pwdata[31:0];
          REG_CENTER_Z:  settings.center_z  = pwdata[31:0];
          REG_SPACING:   settings.spacing   = pwdata[15:0];
          REG_BASE_SIZE: settings.base_size = pwdata[15:0];
          REG_QUAT:      settings.quat      = pwdata;
          default: ;
        endcase
      end
    end
    owed <= expected_positions.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the triangle formation placer
// Drives offset beats and register settings with random stalls on both
// channels, lets formation_check predict and compare, and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import tfp_pkg::*;

  localparam logic [2:0] REG_SPARE_LO     = 3'd6;
  localparam logic [2:0] REG_SPARE_HI     = 3'd7;
  localparam int         DIRECTED_COUNT   = 8;
  localparam int         RANDOM_PHASES    = 8;
  localparam int         BEATS_PER_PHASE  = 222;
  localparam int         HOLD_CYCLES      = 300;
  localparam int         CYCLE_LIMIT      = 400000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;

  int mismatches;
  int positions_owed;
  int positions_checked;
  int beats_sent = 0;
  int settings_used = 0;
  int cycles = 0;
  bit calm = 0;
  bit hold_off = 0;

  triangle_formation_positions_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  formation_check position_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatches        (mismatches),
    .positions_owed    (positions_owed),
    .positions_checked (positions_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a clock edge; returns at the edge where the beat is taken
  task automatic push_beat(input in_item_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // upper pwdata bits of the narrow registers carry junk on purpose
  task automatic apply_setting(input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] cz, input logic [15:0] sp,
                               input logic [15:0] bs, input logic [63:0] q);
    cfg_write(REG_CENTER_X, {$urandom(), cx});
    cfg_write(REG_CENTER_Y, {$urandom(), cy});
    cfg_write(REG_CENTER_Z, {$urandom(), cz});
    cfg_write(REG_SPACING, {$urandom(), 16'($urandom()), sp});
    cfg_write(REG_BASE_SIZE, {$urandom(), 16'($urandom()), bs});
    cfg_write(REG_QUAT, q);
    settings_used++;
  endtask

  // stop offering and wait for every pending result to come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (positions_owed == 0);
    @(posedge clk);
  endtask

  function automatic in_item_t directed_item(input int n);
    in_item_t beat;
    beat = '0;
    case (n)
      1: beat = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh7fff};
      2: beat = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000};
      3: beat = '{-32'sd1, -32'sd1, -32'sd1, -16'sd256};   // zero size at defaults
      4: beat = '{32'sd0, 32'sd0, 32'sd0, -16'sd512};       // negative size mirrors
      5: beat = '{32'sd1, -32'sd1, 32'sh0001_0000, 16'sd1};
      6: beat = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 16'sh7fff};
      7: beat = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 16'sh5555};
      default: ;
    endcase
    return beat;
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom();
      default: return $signed($urandom()) >>> $urandom_range(4, 20);
    endcase
  endfunction

  function automatic logic [15:0] pick_q8();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($urandom());
      default: return $signed(16'($urandom())) >>> $urandom_range(2, 8);
    endcase
  endfunction

  function automatic logic [63:0] pick_rotation();
    case ($urandom_range(0, 6))
      0: return QUAT_RST;
      1: return {16'sd11585, 16'sd0, 16'sd0, 16'sd11585};    // quarter turn about z
      2: return {16'sd0, 16'sd16384, 16'sd0, 16'sd0};        // half turn about x
      3: return {16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}; // third turn about diagonal
      4: return {$urandom(), $urandom()};
      default: return {4{$signed(16'($urandom())) >>> 1}} ^ {$urandom(), $urandom()} >> 2;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t beat;
    beat.offset_x   = pick_q16();
    beat.offset_y   = pick_q16();
    beat.offset_z   = pick_q16();
    beat.size_delta = pick_q8();
    return beat;
  endfunction

  task automatic run_directed();
    for (int n = 0; n < DIRECTED_COUNT; n++) begin
      push_beat(directed_item(n));
    end
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      push_beat(random_item());
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] sp;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    settle();
    apply_setting(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 16'h7fff,
                  64'h7fff_7fff_7fff_7fff);
    cfg_write(REG_SPARE_LO, {$urandom(), $urandom()});
    cfg_write(REG_SPARE_HI, {$urandom(), $urandom()});
    run_directed();
    settle();
    apply_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff, 16'h8000,
                  64'h8000_8000_8000_8000);
    run_directed();
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 7))
        0: sp = 16'd0;
        1, 2: sp = 16'($urandom());
        default: sp = 16'($urandom_range(0, 1024));
      endcase
      if (p == 0) begin
        apply_setting(32'd0, 32'd0, 32'd0, SPACING_RST, BASE_SIZE_RST, QUAT_RST);
      end else begin
        apply_setting(pick_q16(), pick_q16(), pick_q16(), sp, pick_q8(), pick_rotation());
      end
      if ($urandom_range(0, 1)) begin
        cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom(), $urandom()});
      end
      if (p == 2) begin
        hold_off = 1'b1;
      end
      if (p == RANDOM_PHASES - 1) begin
        calm = 1'b1;
      end
      run_random(BEATS_PER_PHASE);
      settle();
    end

    repeat (2 * NUM_STAGES) @(posedge clk);
    $display("covered %0d beats under %0d register settings, %0d results compared",
             beats_sent, settings_used, positions_checked);
    $display("included saturating, mirrored and non-unit rotation cases and a long output stall");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : sink
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        // long back-pressure: the pipeline fills and in_ready drops
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
